FILE: src/pfc_pkg.sv
// Package with payload types, command codes, letter constants and square helpers.
package pfc_pkg;

    localparam int unsigned SIDE    = 5;
    localparam int unsigned CELLS   = 25;
    localparam int unsigned LETTERS = 26;

    localparam logic [4:0] LETTER_I = 5'd8;
    localparam logic [4:0] LETTER_J = 5'd9;
    localparam logic [4:0] LETTER_X = 5'd23;
    localparam logic [4:0] LETTER_Z = 5'd25;

    localparam logic [1:0] CMD_KEY    = 2'd0;
    localparam logic [1:0] CMD_FINISH = 2'd1;
    localparam logic [1:0] CMD_MSG    = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic REG_DECRYPT_MODE = 1'b0;

    typedef struct packed {
        logic [1:0] cmd;
        logic [4:0] letter;
        logic       last;
    } pfc_in_t;

    typedef struct packed {
        logic [4:0] first_letter;
        logic [4:0] second_letter;
        logic       last_pair;
    } pfc_out_t;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
    } pfc_rc_t;

    function automatic logic [4:0] pfc_partner(input logic [4:0] c);
        logic [4:0] p;
        p = c;
        if (c == LETTER_I)
        begin
            p = LETTER_J;
        end
        else if (c == LETTER_J)
        begin
            p = LETTER_I;
        end
        return p;
    endfunction

    function automatic logic [4:0] pfc_canon(input logic [4:0] c);
        logic [4:0] k;
        k = c;
        if (c > LETTER_J)
        begin
            k = c - 5'd1;
        end
        else if (c == LETTER_J)
        begin
            k = LETTER_I;
        end
        return k;
    endfunction

    function automatic pfc_rc_t pfc_split(input logic [4:0] p);
        pfc_rc_t rc;
        logic [4:0] base;
        if (p >= 5'd20)
        begin
            rc.row = 3'd4;
        end
        else if (p >= 5'd15)
        begin
            rc.row = 3'd3;
        end
        else if (p >= 5'd10)
        begin
            rc.row = 3'd2;
        end
        else if (p >= 5'd5)
        begin
            rc.row = 3'd1;
        end
        else
        begin
            rc.row = 3'd0;
        end
        base   = {rc.row, 2'b00} + {2'b00, rc.row};
        rc.col = 3'(p - base);
        return rc;
    endfunction

    function automatic logic [2:0] pfc_shift(input logic [2:0] v, input logic back);
        logic [2:0] r;
        if (back)
        begin
            r = (v == 3'd0) ? 3'(SIDE - 1) : v - 3'd1;
        end
        else
        begin
            r = (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
        end
        return r;
    endfunction

    function automatic logic [4:0] pfc_cell(input logic [2:0] row, input logic [2:0] col);
        return {row, 2'b00} + {2'b00, row} + {2'b00, col};
    endfunction

endpackage

FILE: src/playfair_cipher_engine_top.sv
// Playfair cipher engine: square builder, digraph pairing and cipher transform.
// Each input transaction carries a command, a letter code and a last flag. A key letter
// and a clear complete without leaving idle. The finish command walks the alphabet
// through the square and position memory write ports, one letter per cycle. A message
// letter that closes one digraph passes position memory read, square memory read and
// output load, and one that closes two passes them twice; each output load also waits
// until the output register is free. Letter codes above 25 are dropped. The user must
// write decrypt_mode over APB only while the engine is idle; this is not enforced.
module playfair_cipher_engine_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pfc_pkg::pfc_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output pfc_pkg::pfc_out_t out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import pfc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_POS,
        S_CELL,
        S_OUT
    } state_t;

    state_t        state_reg, state_next;
    logic          mode_reg;
    logic [25:0]   used_reg, used_next;
    logic [4:0]    fill_reg, fill_next;
    logic          ready_reg, ready_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [4:0]    pend_letter_reg, pend_letter_next;
    logic [4:0]    walk_reg, walk_next;
    logic [4:0]    a_reg, a_next;
    logic [4:0]    b_reg, b_next;
    logic          lastp_reg, lastp_next;
    logic          sec_valid_reg, sec_valid_next;
    logic [4:0]    sec_letter_reg, sec_letter_next;
    logic          out_valid_reg, out_valid_next;
    pfc_out_t      out_data_reg, out_data_next;

    logic [4:0]    cell_mem [CELLS];
    logic [4:0]    pos_mem [CELLS];
    logic [4:0]    cell_rd_a_reg, cell_rd_b_reg;
    logic [4:0]    pos_rd_a_reg, pos_rd_b_reg;

    logic          cell_we, pos_we, cell_re, pos_re;
    logic [4:0]    cell_waddr, cell_wdata, pos_waddr, pos_wdata;
    logic [4:0]    cell_raddr_a, cell_raddr_b, pos_raddr_a, pos_raddr_b;

    logic          accept;
    logic          place_try;
    logic [4:0]    place_ltr;
    pfc_rc_t       rc_a, rc_b;
    logic [2:0]    r1, c1, r2, c2;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_DECRYPT_MODE) ? {31'd0, mode_reg} : 32'd0;
    assign accept    = in_valid && in_ready;
    assign rc_a      = pfc_split(pos_rd_a_reg);
    assign rc_b      = pfc_split(pos_rd_b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_DECRYPT_MODE))
        begin
            mode_reg <= pwdata[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cell_we)
        begin
            cell_mem[cell_waddr] <= cell_wdata;
        end
        if (cell_re)
        begin
            cell_rd_a_reg <= cell_mem[cell_raddr_a];
            cell_rd_b_reg <= cell_mem[cell_raddr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
        if (pos_re)
        begin
            pos_rd_a_reg <= pos_mem[pos_raddr_a];
            pos_rd_b_reg <= pos_mem[pos_raddr_b];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        used_next        = used_reg;
        fill_next        = fill_reg;
        ready_next       = ready_reg;
        pend_valid_next  = pend_valid_reg;
        pend_letter_next = pend_letter_reg;
        walk_next        = walk_reg;
        a_next           = a_reg;
        b_next           = b_reg;
        lastp_next       = lastp_reg;
        sec_valid_next   = sec_valid_reg;
        sec_letter_next  = sec_letter_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        place_try        = 1'b0;
        place_ltr        = in_data.letter;
        cell_we          = 1'b0;
        pos_we           = 1'b0;
        cell_re          = 1'b0;
        pos_re           = 1'b0;
        cell_waddr       = fill_reg;
        cell_wdata       = place_ltr;
        pos_waddr        = pfc_canon(place_ltr);
        pos_wdata        = fill_reg;
        pos_raddr_a      = pfc_canon(a_reg);
        pos_raddr_b      = pfc_canon(b_reg);
        r1               = rc_a.row;
        c1               = rc_b.col;
        r2               = rc_b.row;
        c2               = rc_a.col;
        cell_raddr_a     = pfc_cell(r1, c1);
        cell_raddr_b     = pfc_cell(r2, c2);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (in_data.letter < 5'(LETTERS)))
                begin
                    unique case (in_data.cmd)
                        CMD_KEY:
                        begin
                            place_try = !ready_reg;
                        end
                        CMD_FINISH:
                        begin
                            if (!ready_reg)
                            begin
                                walk_next  = 5'd0;
                                state_next = S_FILL;
                            end
                        end
                        CMD_MSG:
                        begin
                            if (ready_reg)
                            begin
                                sec_valid_next  = 1'b0;
                                sec_letter_next = in_data.letter;
                                if (pend_valid_reg && (in_data.letter != pend_letter_reg))
                                begin
                                    a_next           = pend_letter_reg;
                                    b_next           = in_data.letter;
                                    lastp_next       = in_data.last;
                                    pend_valid_next  = 1'b0;
                                    pend_letter_next = 5'd0;
                                    state_next       = S_POS;
                                end
                                else if (pend_valid_reg)
                                begin
                                    a_next         = pend_letter_reg;
                                    b_next         = LETTER_X;
                                    lastp_next     = 1'b0;
                                    sec_valid_next = in_data.last;
                                    state_next     = S_POS;
                                    if (in_data.last)
                                    begin
                                        pend_valid_next  = 1'b0;
                                        pend_letter_next = 5'd0;
                                    end
                                    else
                                    begin
                                        pend_valid_next  = 1'b1;
                                        pend_letter_next = in_data.letter;
                                    end
                                end
                                else if (in_data.last)
                                begin
                                    a_next           = in_data.letter;
                                    b_next           = LETTER_X;
                                    lastp_next       = 1'b1;
                                    pend_valid_next  = 1'b0;
                                    pend_letter_next = 5'd0;
                                    state_next       = S_POS;
                                end
                                else
                                begin
                                    pend_valid_next  = 1'b1;
                                    pend_letter_next = in_data.letter;
                                end
                            end
                        end
                        CMD_CLEAR:
                        begin
                            used_next        = '0;
                            fill_next        = 5'd0;
                            ready_next       = 1'b0;
                            pend_valid_next  = 1'b0;
                            pend_letter_next = 5'd0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FILL:
            begin
                place_try = 1'b1;
                place_ltr = walk_reg;
                if (walk_reg == LETTER_Z)
                begin
                    ready_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    walk_next = walk_reg + 5'd1;
                end
            end
            S_POS:
            begin
                pos_re     = 1'b1;
                state_next = S_CELL;
            end
            S_CELL:
            begin
                if (rc_a.row == rc_b.row)
                begin
                    c1 = pfc_shift(rc_a.col, mode_reg);
                    c2 = pfc_shift(rc_b.col, mode_reg);
                    r2 = rc_b.row;
                    cell_raddr_a = pfc_cell(rc_a.row, c1);
                    cell_raddr_b = pfc_cell(r2, c2);
                end
                else if (rc_a.col == rc_b.col)
                begin
                    r1 = pfc_shift(rc_a.row, mode_reg);
                    r2 = pfc_shift(rc_b.row, mode_reg);
                    cell_raddr_a = pfc_cell(r1, rc_a.col);
                    cell_raddr_b = pfc_cell(r2, rc_b.col);
                end
                cell_re    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.first_letter  = cell_rd_a_reg;
                    out_data_next.second_letter = cell_rd_b_reg;
                    out_data_next.last_pair     = lastp_reg;
                    if (sec_valid_reg)
                    begin
                        a_next         = sec_letter_reg;
                        b_next         = LETTER_X;
                        lastp_next     = 1'b1;
                        sec_valid_next = 1'b0;
                        state_next     = S_POS;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        cell_wdata = place_ltr;
        pos_waddr  = pfc_canon(place_ltr);
        if (place_try && !used_reg[place_ltr] && (fill_reg < 5'(CELLS)))
        begin
            cell_we   = 1'b1;
            pos_we    = 1'b1;
            used_next = used_reg | (26'd1 << place_ltr) | (26'd1 << pfc_partner(place_ltr));
            fill_next = fill_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            used_reg        <= '0;
            fill_reg        <= 5'd0;
            ready_reg       <= 1'b0;
            pend_valid_reg  <= 1'b0;
            pend_letter_reg <= 5'd0;
            walk_reg        <= 5'd0;
            sec_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            a_reg           <= 5'd0;
            b_reg           <= 5'd0;
            lastp_reg       <= 1'b0;
            sec_letter_reg  <= 5'd0;
            out_data_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            used_reg        <= used_next;
            fill_reg        <= fill_next;
            ready_reg       <= ready_next;
            pend_valid_reg  <= pend_valid_next;
            pend_letter_reg <= pend_letter_next;
            walk_reg        <= walk_next;
            sec_valid_reg   <= sec_valid_next;
            out_valid_reg   <= out_valid_next;
            a_reg           <= a_next;
            b_reg           <= b_next;
            lastp_reg       <= lastp_next;
            sec_letter_reg  <= sec_letter_next;
            out_data_reg    <= out_data_next;
        end
    end

endmodule

FILE: dv/playfair_cipher_engine_checker.sv
// Checker for the Playfair cipher engine: watches the channels, predicts digraphs, compares.
module playfair_cipher_engine_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  pfc_pkg::pfc_in_t  in_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  pfc_pkg::pfc_out_t out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    output int                fail_count,
    output int                pending_count,
    output int                in_count,
    output int                out_count
);
    import pfc_pkg::*;

    localparam logic [2:0] ADDR_DECRYPT_MODE = 3'(4 * int'(REG_DECRYPT_MODE));

    logic [4:0]  square_letter [CELLS];
    int          cell_of [LETTERS];
    logic [25:0] placed_mask;
    int          filled;
    logic        ready_flag;
    logic        held_valid;
    logic [4:0]  held_letter;
    logic        decipher;

    pfc_out_t    expected_digraphs [$];
    pfc_out_t    want;
    int          errors;
    int          accepted_items;
    int          seen_digraphs;

    function automatic void queue_digraph(input pfc_out_t d);
        expected_digraphs.insert(expected_digraphs.size(), d);
    endfunction

    function automatic void place_letter(input logic [4:0] c);
        logic [4:0] mate;
        mate = (c == LETTER_I) ? LETTER_J : ((c == LETTER_J) ? LETTER_I : c);
        if (!placed_mask[c] && filled < CELLS)
        begin
            square_letter[filled] = c;
            cell_of[c]            = filled;
            cell_of[mate]         = filled;
            placed_mask[c]        = 1'b1;
            placed_mask[mate]     = 1'b1;
            filled++;
        end
    endfunction

    function automatic pfc_out_t encode_pair(input logic [4:0] a, input logic [4:0] b,
                                             input logic fin);
        int       r1;
        int       c1;
        int       r2;
        int       c2;
        int       shift;
        int       o1;
        int       o2;
        pfc_out_t d;
        r1    = cell_of[a] / SIDE;
        c1    = cell_of[a] % SIDE;
        r2    = cell_of[b] / SIDE;
        c2    = cell_of[b] % SIDE;
        shift = decipher ? SIDE - 1 : 1;
        if (r1 == r2)
        begin
            o1 = r1 * SIDE + (c1 + shift) % SIDE;
            o2 = r2 * SIDE + (c2 + shift) % SIDE;
        end
        else if (c1 == c2)
        begin
            o1 = ((r1 + shift) % SIDE) * SIDE + c1;
            o2 = ((r2 + shift) % SIDE) * SIDE + c2;
        end
        else
        begin
            o1 = r1 * SIDE + c2;
            o2 = r2 * SIDE + c1;
        end
        d.first_letter  = square_letter[o1];
        d.second_letter = square_letter[o2];
        d.last_pair     = fin;
        return d;
    endfunction

    function automatic void clear_square();
        placed_mask = '0;
        filled      = 0;
        ready_flag  = 1'b0;
        held_valid  = 1'b0;
        held_letter = '0;
    endfunction

    function automatic void predict_digraphs(input pfc_in_t t);
        if (t.letter < LETTERS)
        begin
            case (t.cmd)
                CMD_KEY:
                begin
                    if (!ready_flag)
                        place_letter(t.letter);
                end
                CMD_FINISH:
                begin
                    if (!ready_flag)
                    begin
                        for (int c = 0; c < LETTERS; c++)
                            place_letter(5'(c));
                        ready_flag = 1'b1;
                    end
                end
                CMD_MSG:
                begin
                    if (ready_flag)
                    begin
                        if (held_valid && t.letter != held_letter)
                        begin
                            queue_digraph(encode_pair(held_letter, t.letter, t.last));
                            held_valid  = 1'b0;
                            held_letter = '0;
                        end
                        else
                        begin
                            if (held_valid)
                                queue_digraph(encode_pair(held_letter, LETTER_X, 1'b0));
                            if (t.last)
                            begin
                                queue_digraph(encode_pair(t.letter, LETTER_X, 1'b1));
                                held_valid  = 1'b0;
                                held_letter = '0;
                            end
                            else
                            begin
                                held_valid  = 1'b1;
                                held_letter = t.letter;
                            end
                        end
                    end
                end
                CMD_CLEAR:
                begin
                    clear_square();
                end
                default:
                begin
                end
            endcase
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CELLS; k++)
                square_letter[k] = '0;
            for (int k = 0; k < LETTERS; k++)
                cell_of[k] = 0;
            clear_square();
            decipher = 1'b0;
            expected_digraphs.delete();
            errors         = 0;
            accepted_items = 0;
            seen_digraphs  = 0;
            fail_count    <= 0;
            pending_count <= 0;
            in_count      <= 0;
            out_count     <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_DECRYPT_MODE)
                decipher = pwdata[0];
            if (out_valid && out_ready)
            begin
                seen_digraphs++;
                if (expected_digraphs.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected digraph, expected none, actual %0d %0d %0d",
                             $time, out_data.first_letter, out_data.second_letter,
                             out_data.last_pair);
                end
                else
                begin
                    want = expected_digraphs.pop_front();
                    if (want.first_letter !== out_data.first_letter)
                    begin
                        errors++;
                        $display("%0t: first_letter mismatch, expected %0d, actual %0d",
                                 $time, want.first_letter, out_data.first_letter);
                    end
                    if (want.second_letter !== out_data.second_letter)
                    begin
                        errors++;
                        $display("%0t: second_letter mismatch, expected %0d, actual %0d",
                                 $time, want.second_letter, out_data.second_letter);
                    end
                    if (want.last_pair !== out_data.last_pair)
                    begin
                        errors++;
                        $display("%0t: last_pair mismatch, expected %0d, actual %0d",
                                 $time, want.last_pair, out_data.last_pair);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                accepted_items++;
                predict_digraphs(in_data);
            end
            fail_count    <= errors;
            pending_count <= expected_digraphs.size();
            in_count      <= accepted_items;
            out_count     <= seen_digraphs;
        end
    end

endmodule

FILE: dv/playfair_cipher_engine_top_tb.sv
// Testbench top for the Playfair cipher engine: stimulus, handshake idling and verdict.
module playfair_cipher_engine_top_tb;
    import pfc_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned DRAIN_CYCLES  = 60;
    localparam int unsigned ITEM_TARGET   = 700;
    localparam int unsigned SUBPHASES     = 6;
    localparam logic [2:0]  ADDR_DECRYPT_MODE = 3'(4 * int'(REG_DECRYPT_MODE));

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    pfc_in_t     in_data   = '0;
    logic        out_ready = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;

    logic        in_ready;
    logic        out_valid;
    pfc_out_t    out_data;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending_count;
    int          in_count;
    int          out_count;

    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          cycle_count   = 0;
    int          good_count    = 0;
    int          sessions      = 0;

    playfair_cipher_engine_top uut (.*);

    playfair_cipher_engine_checker checker_i (.*);

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d digraphs outstanding",
                     cycle_count, pending_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send(input logic [1:0] cmd, input logic [4:0] letter, input logic last);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{cmd: cmd, letter: letter, last: last};
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic put(input logic [1:0] cmd, input logic [4:0] letter, input logic last,
                       input logic counted);
        if ($urandom_range(99, 0) < 4)
            send(2'($urandom_range(3, 0)), 5'($urandom_range(31, 26)),
                 1'($urandom_range(1, 0)));
        send(cmd, letter, last);
        if (counted)
            good_count++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_count != 0);
    endtask

    task automatic write_decrypt(input logic mode);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_DECRYPT_MODE;
        pwdata  <= {31'($urandom()), mode};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int         perm [26];
        int         swap_idx;
        int         tmp;
        int         key_len;
        int         msg_count;
        int         msg_len;
        int         roll;
        logic [4:0] prev;
        logic [4:0] pick;

        prev = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_decrypt(1'b0);

        send(CMD_MSG, 5'd0, 1'b1);
        send(CMD_KEY, 5'd15, 1'b0);
        send(CMD_KEY, 5'd0, 1'b0);
        send(CMD_KEY, 5'd24, 1'b0);
        send(CMD_KEY, LETTER_J, 1'b0);
        send(CMD_KEY, LETTER_I, 1'b0);
        send(CMD_KEY, 5'd31, 1'b0);
        send(CMD_KEY, LETTER_Z, 1'b1);
        send(CMD_FINISH, 5'd0, 1'b0);
        send(CMD_FINISH, 5'd3, 1'b1);
        send(CMD_KEY, 5'd1, 1'b0);
        send(CMD_MSG, LETTER_I, 1'b0);
        send(CMD_MSG, LETTER_J, 1'b0);
        send(CMD_MSG, LETTER_X, 1'b0);
        send(CMD_MSG, LETTER_X, 1'b0);
        send(CMD_MSG, 5'd7, 1'b0);
        send(CMD_MSG, 5'd7, 1'b1);
        send(CMD_MSG, 5'd0, 1'b0);
        send(CMD_MSG, 5'd0, 1'b0);
        send(CMD_MSG, 5'd30, 1'b1);
        send(CMD_MSG, LETTER_Z, 1'b1);
        send(CMD_MSG, 5'd2, 1'b1);
        send(CMD_CLEAR, 5'd31, 1'b0);
        send(CMD_CLEAR, 5'd4, 1'b1);
        send(CMD_MSG, 5'd4, 1'b1);

        for (int sub = 0; sub < SUBPHASES; sub++)
        begin
            write_decrypt(1'(sub % 2));
            send_idle_pct = (sub / 2 == 0) ? 38 : ((sub / 2 == 1) ? 77 : 0);
            recv_idle_pct = (sub / 2 == 0) ? 77 : ((sub / 2 == 1) ? 38 : 0);
            while (good_count < (sub + 1) * ITEM_TARGET / SUBPHASES)
            begin
                sessions++;
                put(CMD_CLEAR, 5'($urandom_range(25, 0)), 1'($urandom_range(1, 0)), 1'b1);
                if ($urandom_range(99, 0) < 25)
                begin
                    for (int k = 0; k < 26; k++)
                        perm[k] = k;
                    for (int k = 25; k > 0; k--)
                    begin
                        swap_idx       = $urandom_range(k, 0);
                        tmp            = perm[k];
                        perm[k]        = perm[swap_idx];
                        perm[swap_idx] = tmp;
                    end
                    for (int k = 0; k < 26; k++)
                        put(CMD_KEY, 5'(perm[k]), 1'($urandom_range(1, 0)), 1'b1);
                end
                else
                begin
                    key_len = $urandom_range(12, 0);
                    for (int k = 0; k < key_len; k++)
                        put(CMD_KEY, 5'($urandom_range(25, 0)), 1'($urandom_range(1, 0)),
                            1'b1);
                end
                if ($urandom_range(99, 0) < 10)
                    put(CMD_MSG, 5'($urandom_range(25, 0)), 1'($urandom_range(1, 0)), 1'b0);
                put(CMD_FINISH, 5'($urandom_range(25, 0)), 1'($urandom_range(1, 0)), 1'b1);
                msg_count = $urandom_range(4, 1);
                for (int m = 0; m < msg_count; m++)
                begin
                    msg_len = $urandom_range(10, 1);
                    for (int i = 0; i < msg_len; i++)
                    begin
                        roll = $urandom_range(99, 0);
                        if (i > 0 && roll < 18)
                            pick = prev;
                        else if (i > 0 && roll < 26)
                            pick = (prev == LETTER_I) ? LETTER_J : LETTER_I;
                        else if (roll < 36)
                            pick = LETTER_X;
                        else
                            pick = 5'($urandom_range(25, 0));
                        put(CMD_MSG, pick, 1'(i == msg_len - 1), 1'b1);
                        prev = pick;
                    end
                    if ($urandom_range(99, 0) < 10)
                        drain();
                end
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run covered %0d input transactions and %0d digraph results in %0d sessions",
                 in_count, out_count, sessions);
        $display("Both cipher directions, full and partial keys, three handshake idle profiles");
        if (fail_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
